>>> src/srle_pkg.sv
// Shared types and constants for the sample run-length encoder.
package srle_pkg;

    localparam logic [15:0] LOW_GROUP_MASK  = 16'h00ff;
    localparam logic [15:0] HIGH_GROUP_MASK = 16'hff00;
    localparam logic [15:0] SHORT_RUN_MAX   = 16'd128;
    localparam logic [15:0] LONG_RUN_MAX    = 16'd32768;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        REG_GROUP_ONE_DISABLE = 1'b0,
        REG_GROUP_TWO_DISABLE = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic        last;
        logic [15:0] length;
        logic [15:0] value;
    } record_t;

endpackage

>>> src/sample_run_length_encoder.sv
// Top level of the sample run-length encoder: masking, run tracking, record queue.
// Latency: a record enters the output queue at the edge that accepts the word closing it,
// and is offered on m_tvalid from the next cycle.
// Throughput: one input word per cycle while s_tready is high; a word can produce two records, drained
// one per cycle while m_tready is high from a four-entry queue; s_tready drops when more than two are queued.
// Reset (aresetn low, synchronous): no run open, queue empty, both group disables cleared.
module sample_run_length_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input samples
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample_value
    input  logic        s_tlast,   // final_sample
    // output records
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] run_value, [31:16] run_length
    output logic        m_tlast    // last_record
);

    logic g1_dis_reg;
    logic g2_dis_reg;

    logic [15:0] run_val_reg, run_val_next;
    logic [15:0] run_len_reg, run_len_next;

    srle_pkg::record_t queue_reg [srle_pkg::QUEUE_DEPTH];
    logic [srle_pkg::QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [srle_pkg::QUEUE_CW-1:0] count_reg, count_next;

    logic        cfg_wr;
    logic        in_acc;
    logic        out_acc;
    logic [15:0] mask;
    logic [15:0] limit;
    logic [15:0] sample;
    logic        merge;
    logic        brk_valid;
    srle_pkg::record_t rec_first, rec_second;
    logic [1:0]  push_n;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g1_dis_reg <= 1'b0;
            g2_dis_reg <= 1'b0;
        end else if (cfg_wr) begin
            case (srle_pkg::reg_index_t'(paddr[2]))
                srle_pkg::REG_GROUP_ONE_DISABLE: g1_dis_reg <= pwdata[0];
                srle_pkg::REG_GROUP_TWO_DISABLE: g2_dis_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (srle_pkg::reg_index_t'(paddr[2]))
            srle_pkg::REG_GROUP_ONE_DISABLE: prdata = {31'd0, g1_dis_reg};
            srle_pkg::REG_GROUP_TWO_DISABLE: prdata = {31'd0, g2_dis_reg};
            default:                         prdata = 32'd0;
        endcase
    end

    // run tracking
    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    always_comb begin
        mask   = (g1_dis_reg ? 16'd0 : srle_pkg::LOW_GROUP_MASK)
               | (g2_dis_reg ? 16'd0 : srle_pkg::HIGH_GROUP_MASK);
        limit  = (g1_dis_reg || g2_dis_reg) ? srle_pkg::SHORT_RUN_MAX : srle_pkg::LONG_RUN_MAX;
        sample = s_tdata & mask;
        merge  = (run_len_reg != 16'd0) && (sample == run_val_reg) && (run_len_reg < limit);
        brk_valid = !merge && (run_len_reg != 16'd0);

        if (merge) begin
            run_val_next = run_val_reg;
            run_len_next = 16'(run_len_reg + 16'd1);
        end else begin
            run_val_next = sample;
            run_len_next = 16'd1;
        end

        rec_second.value  = run_val_next;
        rec_second.length = run_len_next;
        rec_second.last   = 1'b1;

        if (brk_valid) begin
            rec_first.value  = run_val_reg;
            rec_first.length = run_len_reg;
            rec_first.last   = 1'b0;
        end else begin
            rec_first = rec_second;
        end

        push_n = in_acc ? (2'(brk_valid) + 2'(s_tlast)) : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_val_reg <= 16'd0;
            run_len_reg <= 16'd0;
        end else if (in_acc) begin
            if (s_tlast) begin
                run_val_reg <= 16'd0;
                run_len_reg <= 16'd0;
            end else begin
                run_val_reg <= run_val_next;
                run_len_reg <= run_len_next;
            end
        end
    end

    // record queue
    assign count_next = count_reg + srle_pkg::QUEUE_CW'(push_n)
                      - srle_pkg::QUEUE_CW'(out_acc);
    assign s_tready   = count_reg <= srle_pkg::QUEUE_CW'(srle_pkg::QUEUE_DEPTH - 2);
    assign m_tvalid   = count_reg != '0;
    assign m_tdata    = {queue_reg[rd_ptr_reg].length, queue_reg[rd_ptr_reg].value};
    assign m_tlast    = queue_reg[rd_ptr_reg].last;

    always_ff @(posedge aclk) begin
        for (int i = 0; i < srle_pkg::QUEUE_DEPTH; i++) begin
            if (push_n != 2'd0 && srle_pkg::QUEUE_AW'(i) == wr_ptr_reg) begin
                queue_reg[i] <= rec_first;
            end else if (push_n == 2'd2
                         && srle_pkg::QUEUE_AW'(i) == srle_pkg::QUEUE_AW'(wr_ptr_reg + 1'b1)) begin
                queue_reg[i] <= rec_second;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= srle_pkg::QUEUE_AW'(wr_ptr_reg + srle_pkg::QUEUE_AW'(push_n));
            if (out_acc) begin
                rd_ptr_reg <= srle_pkg::QUEUE_AW'(rd_ptr_reg + 1'b1);
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTH
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= srle_pkg::QUEUE_CW'(srle_pkg::QUEUE_DEPTH))
        else $error("record queue overflow");

    a_room_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |-> (count_reg <= srle_pkg::QUEUE_CW'(srle_pkg::QUEUE_DEPTH - 2)))
        else $error("word accepted without room for two records");

    a_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        run_len_reg <= srle_pkg::LONG_RUN_MAX)
        else $error("open run beyond longest limit");

    a_final_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_tlast) |=> (run_len_reg == 16'd0))
        else $error("run still open after final word");

    a_no_empty_record: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[31:16] != 16'd0))
        else $error("record with zero length offered");
`endif

endmodule

>>> test/tb_sample_run_length_encoder.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sample run-length encoder: directed cases, then random phases.
module tb_sample_run_length_encoder;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [15:0] sample_value
    logic        s_tlast  = 1'b0; // final_sample
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [15:0] run_value, [31:16] run_length
    logic        m_tlast;         // last_record

    sample_run_length_encoder dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predictor state
    logic                grp1_off = 1'b0;
    logic                grp2_off = 1'b0;
    logic [15:0]         run_val  = '0;
    int                  run_len  = 0;
    srle_pkg::record_t   pending_records[$];

    int  err_count  = 0;
    int  n_words    = 0;
    int  n_records  = 0;
    int  n_writes   = 0;
    bit  idle_on    = 1'b1;

    function automatic void predict_runs(logic [15:0] v, logic fin);
        logic [15:0] mask;
        logic [15:0] s;
        int          limit;
        mask = '0;
        if (!grp1_off) mask |= srle_pkg::LOW_GROUP_MASK;
        if (!grp2_off) mask |= srle_pkg::HIGH_GROUP_MASK;
        limit = (grp1_off || grp2_off) ? int'(srle_pkg::SHORT_RUN_MAX)
                                       : int'(srle_pkg::LONG_RUN_MAX);
        s = v & mask;
        if (run_len != 0 && s == run_val && run_len < limit) begin
            run_len++;
        end else begin
            if (run_len != 0)
                pending_records.push_back('{last: 1'b0, length: run_len[15:0], value: run_val});
            run_val = s;
            run_len = 1;
        end
        if (fin) begin
            pending_records.push_back('{last: 1'b1, length: run_len[15:0], value: run_val});
            run_val = '0;
            run_len = 0;
        end
    endfunction

    // result sink with random stalls
    always @(posedge aclk) begin : sink_stall
        static int hold = 0;
        if (hold > 0) begin
            hold--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            hold = $urandom_range(1, 18) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // record checker; handshake is sampled mid-cycle, taken at the next edge
    always @(negedge aclk) begin : record_check
        srle_pkg::record_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_records++;
            if (pending_records.size() == 0) begin
                $error("unexpected record value=%h length=%0d last=%b",
                       m_tdata[15:0], m_tdata[31:16], m_tlast);
                err_count++;
            end else begin
                want = pending_records.pop_front();
                if (m_tdata[15:0] !== want.value) begin
                    $error("run_value expected %h actual %h", want.value, m_tdata[15:0]);
                    err_count++;
                end
                if (m_tdata[31:16] !== want.length) begin
                    $error("run_length expected %0d actual %0d", want.length, m_tdata[31:16]);
                    err_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_record expected %b actual %b", want.last, m_tlast);
                    err_count++;
                end
            end
        end
    end

    task automatic drive_word(logic [15:0] v, logic fin);
        bit ok;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= fin;
        do begin
            @(negedge aclk);
            ok = s_tready;
            @(posedge aclk);
        end while (!ok);
        predict_runs(v, fin);
        n_words++;
    endtask

    task automatic send_run(logic [15:0] v, int count, bit fin_at_end);
        for (int k = 0; k < count; k++)
            drive_word(v, fin_at_end && (k == count - 1));
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_records.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_read(srle_pkg::reg_index_t idx, output logic [31:0] data);
        bit ok;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do begin
            @(negedge aclk);
            ok   = pready;
            data = prdata;
            @(posedge aclk);
        end while (!ok);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_reg(srle_pkg::reg_index_t idx, logic val);
        bit          ok;
        logic [31:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {31'b0, val};
        @(posedge aclk);
        penable <= 1'b1;
        do begin
            @(negedge aclk);
            ok = pready;
            @(posedge aclk);
        end while (!ok);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            srle_pkg::REG_GROUP_ONE_DISABLE: grp1_off = val;
            srle_pkg::REG_GROUP_TWO_DISABLE: grp2_off = val;
            default: ;
        endcase
        n_writes++;
        @(posedge aclk);
        apb_read(idx, rd);
        if (rd[0] !== val) begin
            $error("readback %s expected %b actual %b", idx.name(), val, rd[0]);
            err_count++;
        end
    endtask

    task automatic test_reset_state;
        logic [31:0] rd;
        apb_read(srle_pkg::REG_GROUP_ONE_DISABLE, rd);
        if (rd[0] !== 1'b0) begin
            $error("group_one_disable expected 0 actual %b", rd[0]);
            err_count++;
        end
        apb_read(srle_pkg::REG_GROUP_TWO_DISABLE, rd);
        if (rd[0] !== 1'b0) begin
            $error("group_two_disable expected 0 actual %b", rd[0]);
            err_count++;
        end
    endtask

    task automatic test_basic_runs;
        drive_word(16'h0000, 1'b1);
        drive_word(16'hffff, 1'b1);
        send_run(16'ha5a5, 2, 1'b0);
        send_run(16'h5a5a, 2, 1'b1);
        // break and flush in one word
        drive_word(16'h1234, 1'b0);
        drive_word(16'h4321, 1'b1);
        drain();
    endtask

    task automatic test_group_masks;
        write_reg(srle_pkg::REG_GROUP_ONE_DISABLE, 1'b1);
        drive_word(16'h12ab, 1'b0);
        drive_word(16'h1234, 1'b0);
        drive_word(16'h3400, 1'b1);
        drain();
        write_reg(srle_pkg::REG_GROUP_ONE_DISABLE, 1'b0);
        write_reg(srle_pkg::REG_GROUP_TWO_DISABLE, 1'b1);
        drive_word(16'hab12, 1'b0);
        drive_word(16'hcd12, 1'b1);
        drain();
        write_reg(srle_pkg::REG_GROUP_ONE_DISABLE, 1'b1);
        drive_word(16'hffff, 1'b0);
        drive_word(16'h0000, 1'b0);
        drive_word(16'h1234, 1'b1);
        drain();
        write_reg(srle_pkg::REG_GROUP_ONE_DISABLE, 1'b0);
        write_reg(srle_pkg::REG_GROUP_TWO_DISABLE, 1'b0);
    endtask

    task automatic test_short_limit;
        for (int c = 1; c < 4; c++) begin
            write_reg(srle_pkg::REG_GROUP_ONE_DISABLE, c[0]);
            write_reg(srle_pkg::REG_GROUP_TWO_DISABLE, c[1]);
            send_run(16'h9c3e, 129, 1'b1);
            drain();
        end
        write_reg(srle_pkg::REG_GROUP_ONE_DISABLE, 1'b0);
        write_reg(srle_pkg::REG_GROUP_TWO_DISABLE, 1'b0);
    endtask

    task automatic test_config_mid_run;
        // open run longer than the short limit, then shrink the limit
        send_run(16'h5600, 130, 1'b0);
        drain();
        write_reg(srle_pkg::REG_GROUP_ONE_DISABLE, 1'b1);
        drive_word(16'h56ee, 1'b0);
        drive_word(16'h5611, 1'b1);
        drain();
        // new mask compared against stored run value
        write_reg(srle_pkg::REG_GROUP_ONE_DISABLE, 1'b0);
        send_run(16'h00ab, 3, 1'b0);
        drain();
        write_reg(srle_pkg::REG_GROUP_TWO_DISABLE, 1'b1);
        drive_word(16'hffab, 1'b0);
        drive_word(16'h12ab, 1'b1);
        drain();
        write_reg(srle_pkg::REG_GROUP_TWO_DISABLE, 1'b0);
    endtask

    task automatic test_random_phases;
        logic [15:0] palette[3];
        logic [15:0] v;
        logic [1:0]  cfg;
        int          sent;
        int          len;
        int          r;
        for (int p = 0; p < 5; p++) begin
            drain();
            cfg = (p == 4) ? 2'b00 : p[1:0];
            write_reg(srle_pkg::REG_GROUP_ONE_DISABLE, cfg[0]);
            write_reg(srle_pkg::REG_GROUP_TWO_DISABLE, cfg[1]);
            idle_on = (p != 4);
            for (int i = 0; i < 3; i++) palette[i] = 16'($urandom);
            sent = 0;
            while (sent < 20) begin
                r = $urandom_range(0, 9);
                v = palette[$urandom_range(0, 2)];
                if (r == 7) v = v ^ 16'($urandom & 16'h00ff);
                else if (r == 8) v = v ^ 16'($urandom & 16'hff00);
                else if (r == 9) v = 16'($urandom);
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 12)
                                                   : $urandom_range(1, 5);
                for (int k = 0; k < len; k++) begin
                    drive_word(v, $urandom_range(0, 24) == 0);
                    sent++;
                end
            end
            // close the phase with a final word most of the time
            if ($urandom_range(0, 3) != 0) drive_word(16'($urandom), 1'b1);
        end
        drain();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_basic_runs();
        test_group_masks();
        test_short_limit();
        test_config_mid_run();
        test_random_phases();
        drain();
        repeat (20) @(posedge aclk);
        $display("run covered %0d sample words, %0d records, %0d register writes",
                 n_words, n_records, n_writes);
        $display("configs: both groups, each group alone, none; full runs at the short limit");
        if (err_count == 0 && pending_records.size() == 0) begin
            $display("sample_run_length_encoder: match");
        end else begin
            $display("sample_run_length_encoder: mismatch");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("sample_run_length_encoder: mismatch");
        $finish;
    end

endmodule
